>>> design/brs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants of the bitmap row image store
// Image geometry, command codes, control word and the per-row operator.
// ----------------------------------------------------------------------------
package brs_pkg;

	localparam int IMAGE_SIZE = 64;                 // rows, and bits per row (2..64)
	localparam int ROW_W      = IMAGE_SIZE;
	localparam int DATA_W     = 64;                 // row field width on the channels
	localparam int IDX_W      = 6;                  // row index field width
	localparam int CMD_W      = 3;
	localparam int POS_W      = $clog2(IMAGE_SIZE); // ring position counter

	typedef logic [ROW_W-1:0] row_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD         = 3'd0,
		CMD_COMPLEMENT   = 3'd1,
		CMD_ROTATE_LEFT  = 3'd2,
		CMD_ROTATE_RIGHT = 3'd3,
		CMD_SCROLL_UP    = 3'd4,
		CMD_SCROLL_DOWN  = 3'd5,
		CMD_READ_OUT     = 3'd6
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// sequencer -> datapath
	typedef struct packed {
		logic shift;   // ring advances by one cell
		logic emit;    // head row goes to the output register
		cmd_t op;      // command in progress
		pos_t pos;     // original index of the row now at the head
	} ctl_t;

	// new value entering the tail cell, built from the head row
	function automatic row_t row_op(cmd_t op, row_t head, row_t load_row, logic hit);
		row_t r;
		r = head;
		case (op)
			CMD_LOAD:         r = hit ? load_row : head;
			CMD_COMPLEMENT:   r = ~head;
			CMD_ROTATE_LEFT:  r = {head[ROW_W-2:0], head[ROW_W-1]};
			CMD_ROTATE_RIGHT: r = {head[0], head[ROW_W-1:1]};
			default:          r = head;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/brs_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_cmd_if: command channel
// One word per command: opcode, row index and row bits for a load.
// ----------------------------------------------------------------------------
interface brs_cmd_if;
	import brs_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [IDX_W-1:0]  row_index;
	logic [DATA_W-1:0] row_data;

	modport source (output valid, output cmd, output row_index, output row_data,
		input ready);
	modport sink (input valid, input cmd, input row_index, input row_data,
		output ready);
endinterface
`default_nettype wire

>>> design/brs_row_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_row_if: row read-out channel
// One word per image row, flagged on the last row of the image.
// ----------------------------------------------------------------------------
interface brs_row_if;
	import brs_pkg::*;

	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  out_row_index;
	logic [DATA_W-1:0] out_row_data;
	logic              last_row;

	modport source (output valid, output out_row_index, output out_row_data,
		output last_row, input ready);
	modport sink (input valid, input out_row_index, input out_row_data,
		input last_row, output ready);
endinterface
`default_nettype wire

>>> design/bitmap_row_image_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_row_image_store: square one-bit image held in a ring of row cells
// Load, complement, rotate, scroll and read out of a 64 x 64 bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch takes one command word (cmd, row_index, row_data). row_ch returns
//   one word per row for a read out, rows 0..63 in order, last_row on row 63.
//   The rows sit in a ring of cells; every command but code 7 walks the ring,
//   one cell step per clock while no stalled receiver holds a read out,
//   passing the head row through an operator into the tail. Load, complement,
//   the rotations and read out walk the whole ring, scroll up moves the head
//   row alone, scroll down all but one cell. One command is in work at a time;
//   cmd_ch.ready is high while idle, so a command can be taken in the cycle
//   after the previous one finishes. Read out: first row word appears in the
//   cycle after its ring step; row_ch has an output register, and a stalled
//   receiver freezes the ring. Code 7 is accepted and ignored; a load with
//   row_index out of range walks the ring without changing it.
//   Reset clears every row to zero and leaves the block idle.
// ----------------------------------------------------------------------------
module bitmap_row_image_store (
	input  wire        clk,
	input  wire        arst_n,
	brs_cmd_if.sink    cmd_ch,
	brs_row_if.source  row_ch
);
	import brs_pkg::*;

	ctl_t              ctl;
	row_t              ring [IMAGE_SIZE];
	row_t              feed;
	logic              hit;
	logic [IDX_W-1:0]  idx_q;
	row_t              load_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;

	brs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_ch.valid),
		.cmd       (cmd_ch.cmd),
		.cmd_ready (cmd_ch.ready),
		.out_busy  (out_valid_q && !row_ch.ready),
		.ctl       (ctl)
	);

	always_ff @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			idx_q  <= cmd_ch.row_index;
			load_q <= cmd_ch.row_data[ROW_W-1:0];
		end
	end

	// position compare; a match implies the index is in range
	assign hit  = (IDX_W'(ctl.pos) == idx_q);
	assign feed = row_op(ctl.op, ring[0], load_q, hit);

	// cell i takes cell i+1; the tail takes the processed head
	for (genvar i = 0; i < IMAGE_SIZE; i++) begin : g_cell
		row_t d;
		if (i == IMAGE_SIZE - 1) begin : g_tail
			assign d = feed;
		end else begin : g_body
			assign d = ring[i+1];
		end
		brs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ctl.shift),
			.d      (d),
			.q      (ring[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (row_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_idx_q  <= IDX_W'(ctl.pos);
			out_data_q <= DATA_W'(ring[0]);
			out_last_q <= (ctl.pos == POS_W'(IMAGE_SIZE - 1));
		end
	end

	assign row_ch.valid         = out_valid_q;
	assign row_ch.out_row_index = out_idx_q;
	assign row_ch.out_row_data  = out_data_q;
	assign row_ch.last_row      = out_last_q;
endmodule
`default_nettype wire

>>> design/brs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_cell: one image row of the ring
// Holds a row and takes its neighbor's row whenever the ring shifts.
// ----------------------------------------------------------------------------
module brs_cell (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          shift,
	input  wire brs_pkg::row_t d,
	output brs_pkg::row_t q
);
	import brs_pkg::*;

	row_t row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (shift) begin
			row_q <= d;
		end
	end

	assign q = row_q;
endmodule
`default_nettype wire

>>> design/brs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_ctrl: command sequencer
// Takes a command, then steps the row ring the number of times it needs.
// ----------------------------------------------------------------------------
module brs_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cmd_valid,
	input  wire [brs_pkg::CMD_W-1:0]   cmd,
	output logic                       cmd_ready,
	input  wire                        out_busy,
	output brs_pkg::ctl_t              ctl
);
	import brs_pkg::*;

	state_t state_q, state_nxt;
	cmd_t   cmd_q;
	pos_t   cnt_q;
	pos_t   last_q;
	logic   take;
	logic   step;
	logic   done;

	// code 7 is taken and dropped
	assign take = cmd_valid && cmd_ready && (cmd inside {[CMD_LOAD:CMD_READ_OUT]});
	assign done = (cnt_q == last_q);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) state_nxt = ST_RUN;
			end
			ST_RUN: begin
				if (step && done) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		step      = 1'b0;
		case (state_q)
			ST_IDLE: cmd_ready = 1'b1;
			ST_RUN:  step = (cmd_q != CMD_READ_OUT) || !out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_LOAD;
			cnt_q   <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (take) begin
				cmd_q <= cmd_t'(cmd);
				cnt_q <= '0;
				// scroll up is one ring step, scroll down is all but one
				case (cmd_t'(cmd))
					CMD_SCROLL_UP:   last_q <= '0;
					CMD_SCROLL_DOWN: last_q <= POS_W'(IMAGE_SIZE - 2);
					default:         last_q <= POS_W'(IMAGE_SIZE - 1);
				endcase
			end else if (step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign ctl.shift = step;
	assign ctl.emit  = step && (cmd_q == CMD_READ_OUT);
	assign ctl.op    = cmd_q;
	assign ctl.pos   = cnt_q;
endmodule
`default_nettype wire

>>> sim/image_row_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_row_checker: image mirror and row read-out comparison
// Watches the command and row channels, keeps its own copy of the bitmap,
// queues the rows a read out must return and compares every row word.
// ----------------------------------------------------------------------------
module image_row_checker (
	input  wire  clk,
	input  wire  arst_n,
	brs_cmd_if   cmd_ch,
	brs_row_if   row_ch,
	output int   errors,
	output int   rows_outstanding
);
	import brs_pkg::*;

	typedef struct {
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] data;
		logic              last;
	} row_word_t;

	row_t      image [IMAGE_SIZE];
	row_word_t rows_expected [$];

	initial errors = 0;

	// one command against the mirrored image
	task automatic apply_image_cmd(input logic [CMD_W-1:0] code,
		input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		row_t      wrap;
		row_word_t w;
		case (code)
			CMD_LOAD: begin
				if (idx < IMAGE_SIZE)
					image[idx] = data[ROW_W-1:0];
			end
			CMD_COMPLEMENT: begin
				foreach (image[i]) image[i] = ~image[i];
			end
			CMD_ROTATE_LEFT: begin
				foreach (image[i]) image[i] = (image[i] << 1) | (image[i] >> (ROW_W - 1));
			end
			CMD_ROTATE_RIGHT: begin
				foreach (image[i]) image[i] = (image[i] >> 1) | (image[i] << (ROW_W - 1));
			end
			CMD_SCROLL_UP: begin
				wrap = image[0];
				for (int i = 0; i < IMAGE_SIZE - 1; i++) image[i] = image[i + 1];
				image[IMAGE_SIZE - 1] = wrap;
			end
			CMD_SCROLL_DOWN: begin
				wrap = image[IMAGE_SIZE - 1];
				for (int i = IMAGE_SIZE - 1; i > 0; i--) image[i] = image[i - 1];
				image[0] = wrap;
			end
			CMD_READ_OUT: begin
				for (int i = 0; i < IMAGE_SIZE; i++) begin
					w.index = IDX_W'(i);
					w.data = '0;
					w.data[ROW_W-1:0] = image[i];
					w.last = (i == IMAGE_SIZE - 1);
					rows_expected.push_back(w);
				end
			end
			default: ;  // unused code: no effect
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		row_word_t want;
		if (!arst_n) begin
			foreach (image[i]) image[i] = '0;
			rows_expected.delete();
		end else begin
			// rows in flight belong to older commands, so check them first
			if (row_ch.valid && row_ch.ready) begin
				if (rows_expected.size() == 0) begin
					$error("unexpected row word: out_row_index %0d", row_ch.out_row_index);
					errors++;
				end else begin
					want = rows_expected.pop_front();
					if (row_ch.out_row_index !== want.index) begin
						$error("out_row_index: expected %0d, got %0d",
							want.index, row_ch.out_row_index);
						errors++;
					end
					if (row_ch.out_row_data !== want.data) begin
						$error("out_row_data: expected %h, got %h",
							want.data, row_ch.out_row_data);
						errors++;
					end
					if (row_ch.last_row !== want.last) begin
						$error("last_row: expected %b, got %b", want.last, row_ch.last_row);
						errors++;
					end
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				apply_image_cmd(cmd_ch.cmd, cmd_ch.row_index, cmd_ch.row_data);
		end
		rows_outstanding = rows_expected.size();
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: bitmap row image store
// Directed commands over every opcode and field extreme, then random command
// streams with random sender gaps and receiver stalls; the checker mirrors
// the image and compares each read-out row.
// ----------------------------------------------------------------------------
module testbench;
	import brs_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int RANDOM_CMDS = 380;

	logic clk;
	logic arst_n;
	logic quiet;   // no idling on either side while set
	int   errors;
	int   rows_outstanding;

	brs_cmd_if cmd_ch ();
	brs_row_if row_ch ();

	bitmap_row_image_store dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.row_ch (row_ch)
	);

	image_row_checker chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_ch           (cmd_ch),
		.row_ch           (row_ch),
		.errors           (errors),
		.rows_outstanding (rows_outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#20ms;
		$display("testbench: done, errors");
		$finish;
	end

	// drive one command word and wait until it is taken
	task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [IDX_W-1:0] idx,
		input logic [DATA_W-1:0] data);
		int gap;
		gap = quiet ? 0 : $urandom_range(5);
		if (gap > 0) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid     <= 1'b1;
		cmd_ch.cmd       <= code;
		cmd_ch.row_index <= idx;
		cmd_ch.row_data  <= data;
		do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
	endtask

	// row receiver: random stall before each word
	initial begin : row_sink
		int stall;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(5);
			repeat (stall) begin
				@(negedge clk);
				row_ch.ready <= 1'b0;
			end
			@(negedge clk);
			row_ch.ready <= 1'b1;
			do @(posedge clk); while (!(row_ch.valid && row_ch.ready));
		end
	end

	initial begin : stimulus
		int                pick;
		logic [CMD_W-1:0]  code;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] data;

		arst_n           = 1'b0;
		quiet            = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.cmd       = CMD_LOAD;
		cmd_ch.row_index = '0;
		cmd_ch.row_data  = '0;
		row_ch.ready     = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: cleared image, field extremes, every opcode, ignored fields
		send_cmd(CMD_READ_OUT, '0, '0);
		send_cmd(CMD_LOAD, '0, '1);
		send_cmd(CMD_LOAD, IDX_W'(IMAGE_SIZE - 1), 64'h8000_0000_0000_0001);
		send_cmd(CMD_LOAD, 6'd1, 64'h0123_4567_89AB_CDEF);
		send_cmd(CMD_LOAD, '1, 64'hFEDC_BA98_7654_3210);
		if (IMAGE_SIZE < 2 ** IDX_W)
			send_cmd(CMD_LOAD, IDX_W'(IMAGE_SIZE), '1);  // out of range, dropped
		send_cmd(CMD_LOAD, 6'd2, '1);
		send_cmd(CMD_READ_OUT, '0, '0);
		send_cmd(CMD_ROTATE_LEFT, '0, '0);
		send_cmd(CMD_READ_OUT, '0, '0);
		send_cmd(CMD_ROTATE_RIGHT, '0, '0);
		send_cmd(CMD_ROTATE_RIGHT, '0, '0);
		send_cmd(CMD_READ_OUT, '0, '0);
		send_cmd(CMD_COMPLEMENT, '1, '1);
		send_cmd(CMD_READ_OUT, '0, '0);
		send_cmd(CMD_SCROLL_UP, '0, '0);
		send_cmd(CMD_READ_OUT, '0, '0);
		send_cmd(CMD_SCROLL_DOWN, '0, '0);
		send_cmd(CMD_SCROLL_DOWN, '0, '0);
		send_cmd(CMD_READ_OUT, '0, '0);
		send_cmd(CMD_UNUSED, '1, '1);
		send_cmd(CMD_READ_OUT, '1, '1);

		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 32 == 0)
				quiet = ($urandom_range(3) == 0);
			case ($urandom_range(5))
				0:       data = '0;
				1:       data = '1;
				2:       data = DATA_W'(1) << $urandom_range(DATA_W - 1);
				default: data = {$urandom, $urandom};
			endcase
			idx = IDX_W'($urandom_range(2 ** IDX_W - 1));
			pick = $urandom_range(99);
			if (pick < 45)
				code = CMD_LOAD;
			else if (pick < 51)
				code = CMD_COMPLEMENT;
			else if (pick < 59)
				code = CMD_ROTATE_LEFT;
			else if (pick < 67)
				code = CMD_ROTATE_RIGHT;
			else if (pick < 75)
				code = CMD_SCROLL_UP;
			else if (pick < 83)
				code = CMD_SCROLL_DOWN;
			else if (pick < 97)
				code = CMD_READ_OUT;
			else
				code = CMD_UNUSED;
			send_cmd(code, idx, data);
		end

		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (rows_outstanding != 0) @(negedge clk);
		// last command may still be walking the ring
		repeat (2 * IMAGE_SIZE + 8) @(negedge clk);
		if (errors == 0 && rows_outstanding == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

>>> bitmap_row_image_store.f
design/brs_pkg.sv
design/brs_cmd_if.sv
design/brs_row_if.sv
design/brs_cell.sv
design/brs_ctrl.sv
design/bitmap_row_image_store.sv
sim/image_row_checker.sv
sim/testbench.sv
